FILE: design/wfmm_pkg.sv
// ---------------------------------------------------------------------------
// wfmm_pkg
// shared types, constants and the 16-bit saturation helper of the mixer
// ---------------------------------------------------------------------------
`default_nettype none

package wfmm_pkg;

   // field widths fixed by the interface
   localparam int SPEED_W    = 16;
   localparam int ANGLE_W    = 32;
   localparam int DRIVE_W    = 16;
   localparam int GAIN_BITS  = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CASE_W     = 3;
   localparam int RSP_W      = 4 * DRIVE_W;

   // register stages from input to output register
   localparam int PIPE_DEPTH = 6;

   // register reset values
   localparam int unsigned STRAIGHT_REF_RESET = 0;
   localparam int unsigned NEAR_SIDE_RESET    = 100000;
   localparam int unsigned NEAR_UPPER_RESET   = 220000;
   localparam int unsigned GAIN_BOTH_RESET    = 262;
   localparam int unsigned GAIN_SINGLE_RESET  = 505;
   localparam int unsigned GAIN_SIDE_RESET    = 393;
   localparam int unsigned GAIN_UPPER_RESET   = 262;

   // loop gains
   localparam int HEADING_GAIN = 2000;
   localparam int YAW_GAIN     = 30;
   localparam int DRIVE_GAIN   = 3;
   localparam int TURN_GAIN    = 10;

   // yaw divide by 145 through a reciprocal
   localparam int YAW_DEN     = 145;
   localparam int SCALED_W    = ANGLE_W + 8;
   localparam int MAG_W       = 23;
   localparam int YAW_CLAMP   = YAW_DEN * 32768;
   localparam int RECIP_W     = 24;
   localparam int RECIP_145   = 14810232;
   localparam int RECIP_SHIFT = 31;
   localparam int PROD_W      = MAG_W + RECIP_W;
   localparam int QUO_W       = 17;

   localparam int SAT_MAX = 32767;
   localparam int SAT_MIN = -32768;

   typedef enum logic [2:0] {
      CSR_STRAIGHT_REF,
      CSR_NEAR_SIDE,
      CSR_NEAR_UPPER,
      CSR_GAIN_BOTH,
      CSR_GAIN_SINGLE,
      CSR_GAIN_SIDE,
      CSR_GAIN_UPPER
   } csr_index_type;

   typedef enum logic [CASE_W-1:0] {
      WALL_ALL    = 3'd0,
      WALL_RIGHT  = 3'd1,
      WALL_LEFT   = 3'd2,
      WALL_SIDES  = 3'd3,
      WALL_UPPERS = 3'd4,
      WALL_NONE   = 3'd5
   } wall_case_type;

   function automatic logic signed [DRIVE_W-1:0] sat16(input logic signed [63:0] value);
      if (value > 64'(SAT_MAX)) begin
         sat16 = DRIVE_W'(SAT_MAX);
      end else if (value < 64'(SAT_MIN)) begin
         sat16 = DRIVE_W'(SAT_MIN);
      end else begin
         sat16 = value[DRIVE_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

FILE: design/wall_follow_motor_mixer.sv
// an accepted req transaction passes through the stage registers and the output register to rsp_tvalid
// throughput: one transaction per cycle while rsp_tready is high
// the six-stage pipeline advances as one; a stalled output register holds every stage
// the yaw divide by 145 (reciprocal multiply, then one correction) sets the depth
// reset clears all stage valid bits and loads the register defaults
// ---------------------------------------------------------------------------
// wall_follow_motor_mixer
// pd speed, heading and yaw-rate terms with wall-centering correction,
// mixed into saturated straight and turn drives for both wheels
// ---------------------------------------------------------------------------
`default_nettype none

module wall_follow_motor_mixer
   import wfmm_pkg::*;
#(
   parameter int FRACTION_BITS = 16,
   parameter int DIST_BITS     = 22
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // speed_right, speed_left, target_speed, target_accel, heading,
   // target_heading, target_yaw_rate, target_yaw_accel, dist_upper_left,
   // dist_upper_right, dist_side_left, dist_side_right, zero fill
   input  wire logic [((4*SPEED_W+4*ANGLE_W+4*DIST_BITS+7)/8)*8-1:0] req_tdata,

   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // drive_right, drive_left, turn_right, turn_left
   output      logic [RSP_W-1:0]      rsp_tdata,
   // wall_case
   output      logic [CASE_W-1:0]     rsp_tuser,

   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [2:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // widths that follow from the parameters
   localparam int DIST_LSB = 4 * SPEED_W + 4 * ANGLE_W;
   localparam int HS_W     = ANGLE_W + 4;
   localparam int HP_W     = HS_W + 12;
   localparam int YB       = (FRACTION_BITS + 17 > SCALED_W - 1) ? FRACTION_BITS + 17
                                                                 : SCALED_W - 1;
   localparam int PRE_W    = YB + 5;
   localparam int YAW_W    = YB + 10;
   localparam int DIFF_W   = DIST_BITS + 1;
   localparam int WP_W     = DIST_BITS + 20;
   localparam int SPD_W    = SPEED_W + 4;
   localparam int DSUM_W   = DRIVE_W + 2;

   // ------------------------------------------------------------------
   // configuration registers; the user must write them only while idle, the block does not enforce it
   // ------------------------------------------------------------------
   logic [DIST_BITS-1:0] straight_ref_ff;
   logic [DIST_BITS-1:0] near_side_ff;
   logic [DIST_BITS-1:0] near_upper_ff;
   logic [GAIN_BITS-1:0] gain_both_ff;
   logic [GAIN_BITS-1:0] gain_single_ff;
   logic [GAIN_BITS-1:0] gain_side_ff;
   logic [GAIN_BITS-1:0] gain_upper_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         straight_ref_ff <= DIST_BITS'(STRAIGHT_REF_RESET);
         near_side_ff    <= DIST_BITS'(NEAR_SIDE_RESET);
         near_upper_ff   <= DIST_BITS'(NEAR_UPPER_RESET);
         gain_both_ff    <= GAIN_BITS'(GAIN_BOTH_RESET);
         gain_single_ff  <= GAIN_BITS'(GAIN_SINGLE_RESET);
         gain_side_ff    <= GAIN_BITS'(GAIN_SIDE_RESET);
         gain_upper_ff   <= GAIN_BITS'(GAIN_UPPER_RESET);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_STRAIGHT_REF: straight_ref_ff <= csr_data[DIST_BITS-1:0];
            CSR_NEAR_SIDE:    near_side_ff    <= csr_data[DIST_BITS-1:0];
            CSR_NEAR_UPPER:   near_upper_ff   <= csr_data[DIST_BITS-1:0];
            CSR_GAIN_BOTH:    gain_both_ff    <= csr_data[GAIN_BITS-1:0];
            CSR_GAIN_SINGLE:  gain_single_ff  <= csr_data[GAIN_BITS-1:0];
            CSR_GAIN_SIDE:    gain_side_ff    <= csr_data[GAIN_BITS-1:0];
            CSR_GAIN_UPPER:   gain_upper_ff   <= csr_data[GAIN_BITS-1:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // pipeline control: every stage moves together when the output
   // register is empty or being taken
   // ------------------------------------------------------------------
   logic                  pipe_adv;
   logic [PIPE_DEPTH-1:0] pipe_valid_ff;
   logic [PIPE_DEPTH-1:0] pipe_valid_in;

   assign pipe_adv      = !pipe_valid_ff[PIPE_DEPTH-1] || rsp_tready;
   assign req_tready    = pipe_adv;
   assign pipe_valid_in = {pipe_valid_ff[PIPE_DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= '0;
      end else if (pipe_adv) begin
         pipe_valid_ff <= pipe_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // input field unpacking
   // ------------------------------------------------------------------
   logic signed [SPEED_W-1:0] in_vr, in_vl, in_tv, in_ta;
   logic signed [ANGLE_W-1:0] in_hd, in_th, in_yr, in_ya;
   logic [DIST_BITS-1:0]      in_dul, in_dur, in_dsl, in_dsr;

   assign in_vr  = req_tdata[0*SPEED_W +: SPEED_W];
   assign in_vl  = req_tdata[1*SPEED_W +: SPEED_W];
   assign in_tv  = req_tdata[2*SPEED_W +: SPEED_W];
   assign in_ta  = req_tdata[3*SPEED_W +: SPEED_W];
   assign in_hd  = req_tdata[4*SPEED_W + 0*ANGLE_W +: ANGLE_W];
   assign in_th  = req_tdata[4*SPEED_W + 1*ANGLE_W +: ANGLE_W];
   assign in_yr  = req_tdata[4*SPEED_W + 2*ANGLE_W +: ANGLE_W];
   assign in_ya  = req_tdata[4*SPEED_W + 3*ANGLE_W +: ANGLE_W];
   assign in_dul = req_tdata[DIST_LSB + 0*DIST_BITS +: DIST_BITS];
   assign in_dur = req_tdata[DIST_LSB + 1*DIST_BITS +: DIST_BITS];
   assign in_dsl = req_tdata[DIST_LSB + 2*DIST_BITS +: DIST_BITS];
   assign in_dsr = req_tdata[DIST_LSB + 3*DIST_BITS +: DIST_BITS];

   // ------------------------------------------------------------------
   // stage 1: speed pd terms, heading error sum, yaw scaling by 145,
   // wall presence tests and case selection
   // ------------------------------------------------------------------
   logic signed [SPD_W-1:0]    spd_sum_r, spd_sum_l;
   logic                       r_side, l_side, r_up, l_up;

   logic signed [DRIVE_W-1:0]  s1_spd_r_in, s1_spd_l_in, s1_spd_r_ff, s1_spd_l_ff;
   logic signed [HS_W-1:0]     s1_hsum_in, s1_hsum_ff;
   logic signed [SCALED_W-1:0] s1_yr145_in, s1_yr145_ff, s1_ya145_in, s1_ya145_ff;
   logic signed [SPEED_W-1:0]  s1_vr_in, s1_vr_ff, s1_vl_in, s1_vl_ff;
   logic signed [DIFF_W-1:0]   s1_diff_in, s1_diff_ff;
   logic [GAIN_BITS-1:0]       s1_gain_in, s1_gain_ff;
   wall_case_type              s1_case_in, s1_case_ff;

   always_comb begin
      spd_sum_r   = ((SPD_W'(in_tv) - SPD_W'(in_vr)) <<< 2) + SPD_W'(in_ta);
      spd_sum_l   = ((SPD_W'(in_tv) - SPD_W'(in_vl)) <<< 2) + SPD_W'(in_ta);
      s1_spd_r_in = sat16(64'(spd_sum_r));
      s1_spd_l_in = sat16(64'(spd_sum_l));
      s1_hsum_in  = ((HS_W'(in_th) - HS_W'(in_hd)) <<< 2) + HS_W'(in_yr);
      s1_yr145_in = SCALED_W'(in_yr) * SCALED_W'(YAW_DEN);
      s1_ya145_in = SCALED_W'(in_ya) * SCALED_W'(YAW_DEN);
      s1_vr_in    = in_vr;
      s1_vl_in    = in_vl;
   end

   // wall cases in priority order, first match wins
   always_comb begin
      r_side     = in_dsr < near_side_ff;
      l_side     = in_dsl < near_side_ff;
      r_up       = in_dur < near_upper_ff;
      l_up       = in_dul < near_upper_ff;
      s1_case_in = WALL_NONE;
      s1_diff_in = '0;
      s1_gain_in = '0;
      if (r_side && r_up && l_side && l_up) begin
         s1_case_in = WALL_ALL;
         s1_diff_in = DIFF_W'(in_dul) - DIFF_W'(in_dur);
         s1_gain_in = gain_both_ff;
      end else if (r_side && r_up) begin
         s1_case_in = WALL_RIGHT;
         s1_diff_in = DIFF_W'(straight_ref_ff) - DIFF_W'(in_dur);
         s1_gain_in = gain_single_ff;
      end else if (l_side && l_up) begin
         s1_case_in = WALL_LEFT;
         s1_diff_in = DIFF_W'(in_dul) - DIFF_W'(straight_ref_ff);
         s1_gain_in = gain_single_ff;
      end else if (r_side && l_side) begin
         s1_case_in = WALL_SIDES;
         s1_diff_in = DIFF_W'(in_dsl) - DIFF_W'(in_dsr);
         s1_gain_in = gain_side_ff;
      end else if (r_up && l_up) begin
         s1_case_in = WALL_UPPERS;
         s1_diff_in = DIFF_W'(in_dur) - DIFF_W'(in_dul);
         s1_gain_in = gain_upper_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: heading gain product, yaw numerators, wall gain product
   // ------------------------------------------------------------------
   logic signed [DRIVE_W-1:0] s2_spd_r_ff, s2_spd_l_ff;
   logic signed [HP_W-1:0]    s2_hprod_in, s2_hprod_ff;
   logic signed [PRE_W-1:0]   s2_pre_in [2];
   logic signed [PRE_W-1:0]   s2_pre_ff [2];
   logic signed [WP_W-1:0]    s2_wprod_in, s2_wprod_ff;
   wall_case_type             s2_case_ff;

   always_comb begin
      s2_hprod_in  = HP_W'(s1_hsum_ff) * HP_W'(HEADING_GAIN);
      // right: 4*(145*R - 4*vr*one) + 145*A
      s2_pre_in[0] = ((PRE_W'(s1_yr145_ff) - (PRE_W'(s1_vr_ff) <<< (FRACTION_BITS + 2))) <<< 2)
                     + PRE_W'(s1_ya145_ff);
      // left: 4*(-4*vl*one - 145*R) - 145*A
      s2_pre_in[1] = -(((PRE_W'(s1_yr145_ff) + (PRE_W'(s1_vl_ff) <<< (FRACTION_BITS + 2)))
                        <<< 2) + PRE_W'(s1_ya145_ff));
      s2_wprod_in  = (WP_W'(s1_diff_ff) * WP_W'($signed({1'b0, s1_gain_ff}))) <<< 2;
   end

   // ------------------------------------------------------------------
   // stage 3: heading and wall terms truncated and saturated,
   // yaw numerators scaled by 30
   // ------------------------------------------------------------------
   logic signed [HP_W-1:0]    head_adj, head_quo;
   logic signed [WP_W-1:0]    wall_adj, wall_quo;

   logic signed [DRIVE_W-1:0] s3_spd_r_ff, s3_spd_l_ff;
   logic signed [DRIVE_W-1:0] s3_head_r_in, s3_head_r_ff, s3_head_l_in, s3_head_l_ff;
   logic signed [DRIVE_W-1:0] s3_wall_r_in, s3_wall_r_ff, s3_wall_l_in, s3_wall_l_ff;
   logic signed [YAW_W-1:0]   s3_num_in [2];
   logic signed [YAW_W-1:0]   s3_num_ff [2];
   wall_case_type             s3_case_ff;

   always_comb begin
      // bias negatives so the arithmetic shift truncates toward zero
      head_adj     = s2_hprod_ff + $signed({{(HP_W - FRACTION_BITS){1'b0}},
                                            {FRACTION_BITS{s2_hprod_ff[HP_W-1]}}});
      head_quo     = head_adj >>> FRACTION_BITS;
      s3_head_r_in = sat16(64'(head_quo));
      s3_head_l_in = sat16(-64'(s3_head_r_in));

      wall_adj     = s2_wprod_ff + $signed({{(WP_W - GAIN_BITS){1'b0}},
                                            {GAIN_BITS{s2_wprod_ff[WP_W-1]}}});
      wall_quo     = wall_adj >>> GAIN_BITS;
      s3_wall_r_in = sat16(64'(wall_quo));
      s3_wall_l_in = sat16(-64'(s3_wall_r_in));

      for (int i = 0; i < 2; i++) begin
         s3_num_in[i] = YAW_W'(s2_pre_ff[i]) * YAW_W'(YAW_GAIN);
      end
   end

   // ------------------------------------------------------------------
   // stage 4: straight drives, yaw magnitude over 2^fraction, clamped
   // ------------------------------------------------------------------
   logic signed [DSUM_W-1:0]  drive_sum_r, drive_sum_l;
   logic [YAW_W-1:0]          yaw_mag [2];
   logic [YAW_W-1:0]          yaw_shr [2];

   logic signed [DRIVE_W-1:0] s4_drive_r_in, s4_drive_r_ff, s4_drive_l_in, s4_drive_l_ff;
   logic [MAG_W-1:0]          s4_mag_in [2];
   logic [MAG_W-1:0]          s4_mag_ff [2];
   logic [1:0]                s4_neg_in, s4_neg_ff;
   wall_case_type             s4_case_ff;

   always_comb begin
      drive_sum_r   = DSUM_W'(s3_spd_r_ff) + DSUM_W'(s3_head_r_ff) + DSUM_W'(s3_wall_r_ff);
      drive_sum_l   = DSUM_W'(s3_spd_l_ff) + DSUM_W'(s3_head_l_ff) + DSUM_W'(s3_wall_l_ff);
      s4_drive_r_in = sat16(64'(drive_sum_r) * 64'(DRIVE_GAIN));
      s4_drive_l_in = sat16(64'(drive_sum_l) * 64'(DRIVE_GAIN));

      for (int i = 0; i < 2; i++) begin
         s4_neg_in[i] = s3_num_ff[i][YAW_W-1];
         yaw_mag[i]   = s4_neg_in[i] ? YAW_W'(-s3_num_ff[i]) : YAW_W'(s3_num_ff[i]);
         yaw_shr[i]   = yaw_mag[i] >> FRACTION_BITS;
         // beyond 145*32768 the quotient saturates anyway
         s4_mag_in[i] = (yaw_shr[i] >= YAW_W'(YAW_CLAMP)) ? MAG_W'(YAW_CLAMP)
                                                          : MAG_W'(yaw_shr[i]);
      end
   end

   // ------------------------------------------------------------------
   // stage 5: reciprocal product for the divide by 145
   // ------------------------------------------------------------------
   logic signed [DRIVE_W-1:0] s5_drive_r_ff, s5_drive_l_ff;
   logic [PROD_W-1:0]         s5_prod_in [2];
   logic [PROD_W-1:0]         s5_prod_ff [2];
   logic [MAG_W-1:0]          s5_mag_ff [2];
   logic [1:0]                s5_neg_ff;
   wall_case_type             s5_case_ff;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         s5_prod_in[i] = PROD_W'(s4_mag_ff[i]) * PROD_W'(RECIP_145);
      end
   end

   // ------------------------------------------------------------------
   // stage 6: quotient correction, sign, turn drives, output register
   // ------------------------------------------------------------------
   logic [QUO_W-1:0]          yaw_q0 [2];
   logic [QUO_W-1:0]          yaw_q [2];
   logic [MAG_W-1:0]          yaw_rem [2];
   logic signed [QUO_W:0]     yaw_val [2];
   logic signed [DRIVE_W-1:0] yaw_term [2];
   logic signed [DRIVE_W-1:0] turn_term [2];

   logic [RSP_W-1:0]          rsp_data_in, rsp_data_ff;
   wall_case_type             rsp_case_ff;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         // reciprocal is a shade low, so the estimate is exact or one short
         yaw_q0[i]    = QUO_W'(s5_prod_ff[i] >> RECIP_SHIFT);
         yaw_rem[i]   = s5_mag_ff[i] - MAG_W'(MAG_W'(yaw_q0[i]) * MAG_W'(YAW_DEN));
         yaw_q[i]     = (yaw_rem[i] >= MAG_W'(YAW_DEN)) ? yaw_q0[i] + QUO_W'(1) : yaw_q0[i];
         yaw_val[i]   = s5_neg_ff[i] ? -$signed({1'b0, yaw_q[i]}) : $signed({1'b0, yaw_q[i]});
         yaw_term[i]  = sat16(64'(yaw_val[i]));
         turn_term[i] = sat16(64'(yaw_term[i]) * 64'(TURN_GAIN));
      end
      rsp_data_in = {turn_term[1], turn_term[0], s5_drive_l_ff, s5_drive_r_ff};
   end

   // ------------------------------------------------------------------
   // stage payload registers, no reset needed
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         // stage 1
         s1_spd_r_ff   <= s1_spd_r_in;
         s1_spd_l_ff   <= s1_spd_l_in;
         s1_hsum_ff    <= s1_hsum_in;
         s1_yr145_ff   <= s1_yr145_in;
         s1_ya145_ff   <= s1_ya145_in;
         s1_vr_ff      <= s1_vr_in;
         s1_vl_ff      <= s1_vl_in;
         s1_diff_ff    <= s1_diff_in;
         s1_gain_ff    <= s1_gain_in;
         s1_case_ff    <= s1_case_in;
         // stage 2
         s2_spd_r_ff   <= s1_spd_r_ff;
         s2_spd_l_ff   <= s1_spd_l_ff;
         s2_hprod_ff   <= s2_hprod_in;
         s2_pre_ff     <= s2_pre_in;
         s2_wprod_ff   <= s2_wprod_in;
         s2_case_ff    <= s1_case_ff;
         // stage 3
         s3_spd_r_ff   <= s2_spd_r_ff;
         s3_spd_l_ff   <= s2_spd_l_ff;
         s3_head_r_ff  <= s3_head_r_in;
         s3_head_l_ff  <= s3_head_l_in;
         s3_wall_r_ff  <= s3_wall_r_in;
         s3_wall_l_ff  <= s3_wall_l_in;
         s3_num_ff     <= s3_num_in;
         s3_case_ff    <= s2_case_ff;
         // stage 4
         s4_drive_r_ff <= s4_drive_r_in;
         s4_drive_l_ff <= s4_drive_l_in;
         s4_mag_ff     <= s4_mag_in;
         s4_neg_ff     <= s4_neg_in;
         s4_case_ff    <= s3_case_ff;
         // stage 5
         s5_drive_r_ff <= s4_drive_r_ff;
         s5_drive_l_ff <= s4_drive_l_ff;
         s5_prod_ff    <= s5_prod_in;
         s5_mag_ff     <= s4_mag_ff;
         s5_neg_ff     <= s4_neg_ff;
         s5_case_ff    <= s4_case_ff;
         // output register
         rsp_data_ff   <= rsp_data_in;
         rsp_case_ff   <= s5_case_ff;
      end
   end

   assign rsp_tvalid = pipe_valid_ff[PIPE_DEPTH-1];
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_case_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> pipe_valid_ff[0])
      else $error("accepted transaction missing from first stage");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !pipe_adv |=> $stable(pipe_valid_ff))
      else $error("stage valid bits moved during a stall");

   a_rsp_from_stage5: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(pipe_valid_ff[PIPE_DEPTH-2]))
      else $error("result appeared without a transaction in the last stage");

   a_recip_one_short: assert property (@(posedge clock) disable iff (reset)
      pipe_valid_ff[PIPE_DEPTH-2] |-> (yaw_rem[0] < MAG_W'(2 * YAW_DEN)) &&
                                      (yaw_rem[1] < MAG_W'(2 * YAW_DEN)))
      else $error("yaw reciprocal estimate off by more than one");

endmodule

`default_nettype wire
